// File: src/qcas_pkg.sv
package qcas_pkg;

  localparam int COORD_W = 12;
  localparam int AREA_W  = 25;
  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

  localparam logic [3:0] QUAD_COUNT = 4'd4;

  localparam int NCORN  = 4;
  localparam int NPAIRS = 6;

  // compare-swap schedule, one pair per stage
  localparam int PAIR_I [NPAIRS] = '{0, 0, 0, 1, 1, 2};
  localparam int PAIR_J [NPAIRS] = '{1, 2, 3, 2, 3, 3};

  // half-plane codes, ordered by angle
  localparam logic [1:0] HALF_NEG  = 2'd0;
  localparam logic [1:0] HALF_ZERO = 2'd1;
  localparam logic [1:0] HALF_POS  = 2'd2;

endpackage

// File: src/quad_corner_angle_sort_area.sv
// Orders four corners by polar angle around their mean and reports twice the
// quadrilateral area. The block is a fixed pipeline of 11 register stages: one
// quad is taken every cycle while the output is not stalled, the depth being
// set by the six compare-swap stages of the sort plus input, offset and three
// area stages. Quads whose blob_count is not four are taken and dropped with
// no result. When a result is not taken the whole pipeline holds, and in_ready
// follows the output side.
module quad_corner_angle_sort_area #(
  parameter int COORD_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [3:0]                      blob_count,
  input  logic [qcas_pkg::COORD_W-1:0]    x0,
  input  logic [qcas_pkg::COORD_W-1:0]    y0,
  input  logic [qcas_pkg::COORD_W-1:0]    x1,
  input  logic [qcas_pkg::COORD_W-1:0]    y1,
  input  logic [qcas_pkg::COORD_W-1:0]    x2,
  input  logic [qcas_pkg::COORD_W-1:0]    y2,
  input  logic [qcas_pkg::COORD_W-1:0]    x3,
  input  logic [qcas_pkg::COORD_W-1:0]    y3,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [qcas_pkg::COORD_W-1:0]    sorted_x0,
  output logic [qcas_pkg::COORD_W-1:0]    sorted_y0,
  output logic [qcas_pkg::COORD_W-1:0]    sorted_x1,
  output logic [qcas_pkg::COORD_W-1:0]    sorted_y1,
  output logic [qcas_pkg::COORD_W-1:0]    sorted_x2,
  output logic [qcas_pkg::COORD_W-1:0]    sorted_y2,
  output logic [qcas_pkg::COORD_W-1:0]    sorted_x3,
  output logic [qcas_pkg::COORD_W-1:0]    sorted_y3,
  output logic [qcas_pkg::AREA_W-1:0]     twice_area
);
  import qcas_pkg::*;

  // coordinates beyond the port width carry nothing
  localparam int CB    = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam int S_W   = CB + 2;
  localparam int D_W   = CB + 3;
  localparam int V_W   = CB + 1;
  localparam int M_W   = 2 * V_W;
  localparam int X_W   = M_W + 1;
  localparam int ABS_W = 2 * CB + 1;
  localparam int SUM_W = ABS_W + 1;
  localparam int CMP_W = (SUM_W > AREA_W) ? SUM_W : AREA_W;

  logic en;

  // input stage
  logic          valid0;
  logic [CB-1:0] px0 [4];
  logic [CB-1:0] py0 [4];

  // offsets from the mean, scaled by four
  logic [S_W-1:0]        sum_x;
  logic [S_W-1:0]        sum_y;
  logic signed [D_W-1:0] dx_c [4];
  logic signed [D_W-1:0] dy_c [4];

  // sort pipeline, entry 0 feeds the first compare-swap
  logic                  valid_s [NPAIRS+1];
  logic [CB-1:0]         px_s [NPAIRS+1][4];
  logic [CB-1:0]         py_s [NPAIRS+1][4];
  logic signed [D_W-1:0] dx_s [NPAIRS+1][4];
  logic signed [D_W-1:0] dy_s [NPAIRS+1][4];

  // area stages
  logic signed [V_W-1:0] ax1, ay1, ax2, ay2, ax3, ay3;
  logic                  valid_m;
  logic [CB-1:0]         px_m [4];
  logic [CB-1:0]         py_m [4];
  logic signed [M_W-1:0] m1a, m1b, m2a, m2b;
  logic signed [X_W-1:0] c1, c2;
  logic                  valid_a;
  logic [CB-1:0]         px_a [4];
  logic [CB-1:0]         py_a [4];
  logic [ABS_W-1:0]      abs1, abs2;
  logic [SUM_W-1:0]      area_sum;
  logic                  area_sat;
  logic [CB-1:0]         px_o [4];
  logic [CB-1:0]         py_o [4];
  logic [AREA_W-1:0]     area_o;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
    end else if (en) begin
      valid0 <= in_valid && (blob_count == QUAD_COUNT);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px0[0] <= x0[CB-1:0];
      py0[0] <= y0[CB-1:0];
      px0[1] <= x1[CB-1:0];
      py0[1] <= y1[CB-1:0];
      px0[2] <= x2[CB-1:0];
      py0[2] <= y2[CB-1:0];
      px0[3] <= x3[CB-1:0];
      py0[3] <= y3[CB-1:0];
    end
  end

  assign sum_x = S_W'(px0[0]) + S_W'(px0[1]) + S_W'(px0[2]) + S_W'(px0[3]);
  assign sum_y = S_W'(py0[0]) + S_W'(py0[1]) + S_W'(py0[2]) + S_W'(py0[3]);

  always_comb begin
    for (int k = 0; k < NCORN; k++) begin
      dx_c[k] = $signed(D_W'({px0[k], 2'b00})) - $signed(D_W'(sum_x));
      dy_c[k] = $signed(D_W'({py0[k], 2'b00})) - $signed(D_W'(sum_y));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s[0] <= 1'b0;
    end else if (en) begin
      valid_s[0] <= valid0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_s[0] <= px0;
      py_s[0] <= py0;
      dx_s[0] <= dx_c;
      dy_s[0] <= dy_c;
    end
  end

  for (genvar g = 0; g < NPAIRS; g++) begin : g_sort
    qcas_cswap #(
      .P_W (CB),
      .D_W (D_W),
      .I   (PAIR_I[g]),
      .J   (PAIR_J[g])
    ) u_cswap (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .valid_in  (valid_s[g]),
      .px_in     (px_s[g]),
      .py_in     (py_s[g]),
      .dx_in     (dx_s[g]),
      .dy_in     (dy_s[g]),
      .valid_out (valid_s[g+1]),
      .px_out    (px_s[g+1]),
      .py_out    (py_s[g+1]),
      .dx_out    (dx_s[g+1]),
      .dy_out    (dy_s[g+1])
    );
  end

  // edge vectors from the first sorted corner
  assign ax1 = $signed({1'b0, px_s[NPAIRS][1]}) - $signed({1'b0, px_s[NPAIRS][0]});
  assign ay1 = $signed({1'b0, py_s[NPAIRS][1]}) - $signed({1'b0, py_s[NPAIRS][0]});
  assign ax2 = $signed({1'b0, px_s[NPAIRS][2]}) - $signed({1'b0, px_s[NPAIRS][0]});
  assign ay2 = $signed({1'b0, py_s[NPAIRS][2]}) - $signed({1'b0, py_s[NPAIRS][0]});
  assign ax3 = $signed({1'b0, px_s[NPAIRS][3]}) - $signed({1'b0, px_s[NPAIRS][0]});
  assign ay3 = $signed({1'b0, py_s[NPAIRS][3]}) - $signed({1'b0, py_s[NPAIRS][0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_m <= 1'b0;
      valid_a <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      valid_m <= valid_s[NPAIRS];
      valid_a <= valid_m;
      out_valid <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_m <= px_s[NPAIRS];
      py_m <= py_s[NPAIRS];
      m1a  <= ax1 * ay2;
      m1b  <= ay1 * ax2;
      m2a  <= ax2 * ay3;
      m2b  <= ay2 * ax3;
    end
  end

  assign c1 = X_W'(m1a) - X_W'(m1b);
  assign c2 = X_W'(m2a) - X_W'(m2b);

  always_ff @(posedge clk) begin
    if (en) begin
      px_a <= px_m;
      py_a <= py_m;
      abs1 <= c1[X_W-1] ? ABS_W'(-c1) : ABS_W'(c1);
      abs2 <= c2[X_W-1] ? ABS_W'(-c2) : ABS_W'(c2);
    end
  end

  assign area_sum = SUM_W'(abs1) + SUM_W'(abs2);
  assign area_sat = CMP_W'(area_sum) > CMP_W'(AREA_MAX);

  always_ff @(posedge clk) begin
    if (en) begin
      px_o   <= px_a;
      py_o   <= py_a;
      area_o <= area_sat ? AREA_MAX : AREA_W'(area_sum);
    end
  end

  assign sorted_x0  = COORD_W'(px_o[0]);
  assign sorted_y0  = COORD_W'(py_o[0]);
  assign sorted_x1  = COORD_W'(px_o[1]);
  assign sorted_y1  = COORD_W'(py_o[1]);
  assign sorted_x2  = COORD_W'(px_o[2]);
  assign sorted_y2  = COORD_W'(py_o[2]);
  assign sorted_x3  = COORD_W'(px_o[3]);
  assign sorted_y3  = COORD_W'(py_o[3]);
  assign twice_area = area_o;

endmodule

// File: src/qcas_cswap.sv
module qcas_cswap #(
  parameter int P_W = 12,
  parameter int D_W = 15,
  parameter int I   = 0,
  parameter int J   = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  valid_in,
  input  logic [P_W-1:0]        px_in [4],
  input  logic [P_W-1:0]        py_in [4],
  input  logic signed [D_W-1:0] dx_in [4],
  input  logic signed [D_W-1:0] dy_in [4],
  output logic                  valid_out,
  output logic [P_W-1:0]        px_out [4],
  output logic [P_W-1:0]        py_out [4],
  output logic signed [D_W-1:0] dx_out [4],
  output logic signed [D_W-1:0] dy_out [4]
);
  import qcas_pkg::*;

  localparam int X_W = 2 * D_W + 1;

  logic [1:0]             half_j;
  logic [1:0]             half_i;
  logic signed [2*D_W-1:0] prod_a;
  logic signed [2*D_W-1:0] prod_b;
  logic signed [X_W-1:0]  cross_val;
  logic                   swap;

  function automatic logic [1:0] half_of(input logic signed [D_W-1:0] x,
                                         input logic signed [D_W-1:0] y);
    logic [1:0] h;
    if (y[D_W-1]) begin
      h = HALF_NEG;
    end else if (y == '0 && !x[D_W-1]) begin
      h = HALF_ZERO;
    end else begin
      h = HALF_POS;
    end
    return h;
  endfunction

  assign half_j    = half_of(dx_in[J], dy_in[J]);
  assign half_i    = half_of(dx_in[I], dy_in[I]);
  assign prod_a    = dx_in[J] * dy_in[I];
  assign prod_b    = dy_in[J] * dx_in[I];
  assign cross_val = X_W'(prod_a) - X_W'(prod_b);

  // swap when corner j lies at a strictly smaller angle than corner i
  always_comb begin
    if (half_j != half_i) begin
      swap = (half_j < half_i);
    end else if (half_j == HALF_ZERO) begin
      swap = 1'b0;
    end else begin
      swap = !cross_val[X_W-1] && (cross_val != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NCORN; k++) begin
        if (swap && k == I) begin
          px_out[k] <= px_in[J];
          py_out[k] <= py_in[J];
          dx_out[k] <= dx_in[J];
          dy_out[k] <= dy_in[J];
        end else if (swap && k == J) begin
          px_out[k] <= px_in[I];
          py_out[k] <= py_in[I];
          dx_out[k] <= dx_in[I];
          dy_out[k] <= dy_in[I];
        end else begin
          px_out[k] <= px_in[k];
          py_out[k] <= py_in[k];
          dx_out[k] <= dx_in[k];
          dy_out[k] <= dy_in[k];
        end
      end
    end
  end

endmodule
